>>> hw/rtl/rvg_pkg.sv
// ----------------------------------------------------------------------------
// rvg_pkg - shared types and constants for the radial vignetting gain block
// Field layout, register indexes, fixed-point widths and the root table used
// by the power stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rvg_pkg;

    // stream layout, 16-bit fields
    localparam int FIELD_W    = 16;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 64;
    localparam int X_LSB      = 0;
    localparam int Y_LSB      = 16;
    localparam int R_LSB      = 32;
    localparam int G_LSB      = 48;
    localparam int B_LSB      = 64;
    localparam int A_LSB      = 80;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DENSITY      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POWER        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ADD_VIG      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SIXTEEN      = 3'd7;

    localparam logic [15:0] POWER_RESET = 16'd4096;

    // fixed-point widths
    localparam int RAD_W     = 17;  // radii
    localparam int T_W       = 17;  // ramp position, Q0.16 up to 1.0
    localparam int K_W       = 5;   // normalising shift
    localparam int FRAC_W    = 16;  // log / exp fraction bits
    localparam int LG_W      = 21;  // log2 magnitude, Q5.16
    localparam int P_W       = 25;  // log2 times power, Q9.16
    localparam int IP_W      = 5;   // integer part kept when below 17
    localparam int R_W       = 31;  // exp accumulator, Q1.30
    localparam int ROOT_W    = 30;
    localparam int GAIN_W    = 22;  // gain, Q6.16
    localparam int LOG_STEPS = 16;
    localparam int EXP_STEPS = 16;

    localparam logic [T_W-1:0] ONE_Q16 = 17'd65536;

    // gain selection
    typedef logic [1:0] gsel_t;
    localparam gsel_t SEL_UNITY = 2'd0;
    localparam gsel_t SEL_EDGE  = 2'd1;
    localparam gsel_t SEL_RAMP  = 2'd2;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] r;
        logic [63:0] b;
        rem = v;
        r   = '0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(30 - 2^-n) style root: R_1 = isqrt(2^59), R_n = isqrt(R_(n-1) << 30)
    function automatic logic [ROOT_W-1:0] exp_root(input int n);
        logic [63:0] root;
        root = 64'd1 << 29;
        for (int j = 1; j <= n; j++) begin
            root = isqrt64(root << 30);
        end
        return root[ROOT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/rvg_div.sv
// ----------------------------------------------------------------------------
// rvg_div - pipelined restoring divider
// One quotient bit per stage. Computes (num << (QUO_W-1)) / den where
// num < 2*den, with a side payload carried alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvg_div #(
    parameter int DEN_W = 17,
    parameter int QUO_W = 17,
    parameter int PAY_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DEN_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic [PAY_W-1:0] in_pay,
    output logic             out_valid,
    output logic [QUO_W-1:0] out_quo,
    output logic [PAY_W-1:0] out_pay
);

    localparam int RMW = DEN_W + 1;

    logic [RMW-1:0]   rem_reg   [QUO_W];
    logic [DEN_W-1:0] den_reg   [QUO_W];
    logic [QUO_W-1:0] quo_reg   [QUO_W];
    logic [PAY_W-1:0] pay_reg   [QUO_W];
    logic             valid_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_step
        logic [RMW-1:0]   rem_in;
        logic [RMW-1:0]   cand;
        logic [RMW-1:0]   rem_next;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [QUO_W-1:0] quo_next;
        logic [PAY_W-1:0] pay_in;
        logic             valid_in;

        if (i == 0) begin : g_first
            assign rem_in   = RMW'(in_num);
            assign cand     = rem_in;
            assign den_in   = in_den;
            assign quo_in   = '0;
            assign pay_in   = in_pay;
            assign valid_in = in_valid;
        end else begin : g_next
            assign rem_in   = rem_reg[i-1];
            assign cand     = {rem_in[DEN_W-1:0], 1'b0};
            assign den_in   = den_reg[i-1];
            assign quo_in   = quo_reg[i-1];
            assign pay_in   = pay_reg[i-1];
            assign valid_in = valid_reg[i-1];
        end

        always_comb begin
            if (cand >= {1'b0, den_in}) begin
                rem_next = cand - {1'b0, den_in};
                quo_next = {quo_in[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = cand;
                quo_next = {quo_in[QUO_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= rem_next;
                den_reg[i] <= den_in;
                quo_reg[i] <= quo_next;
                pay_reg[i] <= pay_in;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_pay   = pay_reg[QUO_W-1];

endmodule

>>> hw/rtl/radial_vignetting_gain_top.sv
// ----------------------------------------------------------------------------
// radial_vignetting_gain_top - radial vignetting gain, one pixel per clock
// Each transfer carries one RGBA pixel and its column and row. The block
// takes the rounded distance from the configured centre and builds a gain:
// one inside the inner radius, one plus density beyond the outer radius and
// 1 + density * ((d - inner) / (outer - inner)) ^ power in between, or the
// reciprocal of that in add mode. Red, green and blue are scaled by the gain,
// truncated and clamped to 255 or to the full sample range; alpha passes
// through. The datapath is a single pipeline that takes a new pixel every
// cycle while the output side accepts; most of its stages lie in the
// bit-serial square root (COORD_BITS + 1 stages), two 17-stage dividers,
// 16 log2 squaring stages and 16 exp2 root stages. When the output
// register is held the whole pipeline holds with it and s_tready drops.
// Configuration must be written only while no pixel is in flight; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radial_vignetting_gain_top #(
    parameter int COORD_BITS  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [rvg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rvg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // pixel in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // x_pos, y_pos, red_in, green_in, blue_in, alpha_in (16 bit each, low up)
    input  logic [rvg_pkg::S_TDATA_W-1:0]   s_tdata,
    // pixel out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // red_out, green_out, blue_out, alpha_out (16 bit each, low up)
    output logic [rvg_pkg::M_TDATA_W-1:0]   m_tdata
);

    import rvg_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int SW   = SAMPLE_BITS;
    localparam int PIXW = 4 * SW;          // {alpha, blue, green, red}
    localparam int PSW  = 2 + PIXW;        // {gain select, pixel}
    localparam int SQW  = 2 * CW + 1;      // sum of squares
    localparam int NQ   = CW + 1;          // root bits = sqrt stages
    localparam int SP   = 2 * NQ;          // padded radicand
    localparam int RW   = NQ + 2;          // sqrt remainder
    localparam int DW   = NQ + 1;          // rounded distance
    localparam int CMPW = (DW > RAD_W) ? DW : RAD_W;
    localparam int VW   = SW + GAIN_W - 16; // scaled sample before clamp

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]      center_x_reg;
    logic [15:0]      center_y_reg;
    logic [RAD_W-1:0] inner_radius_reg;
    logic [RAD_W-1:0] outer_radius_reg;
    logic [15:0]      density_reg;
    logic [15:0]      falloff_power_reg;
    logic             add_vignetting_reg;
    logic             sixteen_bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg       <= '0;
            center_y_reg       <= '0;
            inner_radius_reg   <= '0;
            outer_radius_reg   <= '0;
            density_reg        <= '0;
            falloff_power_reg  <= POWER_RESET;
            add_vignetting_reg <= 1'b0;
            sixteen_bit_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CENTER_X:     center_x_reg       <= cfg_wdata[15:0];
                REG_CENTER_Y:     center_y_reg       <= cfg_wdata[15:0];
                REG_INNER_RADIUS: inner_radius_reg   <= cfg_wdata[RAD_W-1:0];
                REG_OUTER_RADIUS: outer_radius_reg   <= cfg_wdata[RAD_W-1:0];
                REG_DENSITY:      density_reg        <= cfg_wdata[15:0];
                REG_POWER:        falloff_power_reg  <= cfg_wdata[15:0];
                REG_ADD_VIG:      add_vignetting_reg <= cfg_wdata[0];
                REG_SIXTEEN:      sixteen_bit_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves together unless the output
    // register holds a transfer that has not been taken.
    // ------------------------------------------------------------------
    logic en;
    logic out_v_reg;

    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: absolute offsets from the centre
    // ------------------------------------------------------------------
    logic [CW-1:0]   x_c, y_c, cx_c, cy_c;
    logic [CW-1:0]   dx_next, dy_next;
    logic [PIXW-1:0] pix_in;
    logic [CW-1:0]   dx_reg, dy_reg;
    logic [PIXW-1:0] pix1_reg;
    logic            v1_reg;

    assign x_c     = s_tdata[X_LSB +: CW];
    assign y_c     = s_tdata[Y_LSB +: CW];
    assign cx_c    = center_x_reg[CW-1:0];
    assign cy_c    = center_y_reg[CW-1:0];
    assign dx_next = (x_c >= cx_c) ? x_c - cx_c : cx_c - x_c;
    assign dy_next = (y_c >= cy_c) ? y_c - cy_c : cy_c - y_c;
    assign pix_in  = {s_tdata[A_LSB +: SW], s_tdata[B_LSB +: SW],
                      s_tdata[G_LSB +: SW], s_tdata[R_LSB +: SW]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            pix1_reg <= pix_in;
        end
    end

    // ------------------------------------------------------------------
    // Stages 2-3: squares, then their sum
    // ------------------------------------------------------------------
    logic [2*CW-1:0] dxx_reg, dyy_reg;
    logic [PIXW-1:0] pix2_reg, pix3_reg;
    logic            v2_reg, v3_reg;
    logic [SQW-1:0]  ssq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dxx_reg  <= dx_reg * dx_reg;
            dyy_reg  <= dy_reg * dy_reg;
            pix2_reg <= pix1_reg;
            ssq_reg  <= SQW'(dxx_reg) + SQW'(dyy_reg);
            pix3_reg <= pix2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root, one root bit per stage
    // ------------------------------------------------------------------
    logic [SP-1:0]   sq_s_reg    [NQ];
    logic [RW-1:0]   sq_rem_reg  [NQ];
    logic [NQ-1:0]   sq_root_reg [NQ];
    logic [PIXW-1:0] sq_pix_reg  [NQ];
    logic            sq_v_reg    [NQ];

    for (genvar j = 0; j < NQ; j++) begin : g_sqrt
        logic [SP-1:0]   s_in;
        logic [RW-1:0]   rem_in, rem_next;
        logic [NQ-1:0]   root_in, root_next;
        logic [PIXW-1:0] pix_j;
        logic            v_in;
        logic [1:0]      pair;
        logic [RW+1:0]   cand, trial;

        if (j == 0) begin : g_first
            assign s_in    = {1'b0, ssq_reg};
            assign rem_in  = '0;
            assign root_in = '0;
            assign pix_j   = pix3_reg;
            assign v_in    = v3_reg;
        end else begin : g_next
            assign s_in    = sq_s_reg[j-1];
            assign rem_in  = sq_rem_reg[j-1];
            assign root_in = sq_root_reg[j-1];
            assign pix_j   = sq_pix_reg[j-1];
            assign v_in    = sq_v_reg[j-1];
        end

        assign pair  = s_in[SP-1-2*j -: 2];
        assign cand  = {rem_in, pair};
        assign trial = (RW+2)'({root_in, 2'b01});

        always_comb begin
            if (cand >= trial) begin
                rem_next  = RW'(cand - trial);
                root_next = {root_in[NQ-2:0], 1'b1};
            end else begin
                rem_next  = RW'(cand);
                root_next = {root_in[NQ-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[j] <= 1'b0;
            end else if (en) begin
                sq_v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_s_reg[j]    <= s_in;
                sq_rem_reg[j]  <= rem_next;
                sq_root_reg[j] <= root_next;
                sq_pix_reg[j]  <= pix_j;
            end
        end
    end

    // ------------------------------------------------------------------
    // Round to nearest: bump when remainder exceeds the root
    // ------------------------------------------------------------------
    logic [NQ-1:0]   q_fin;
    logic [RW-1:0]   rem_fin;
    logic [DW-1:0]   dist_next, dist_reg;
    logic [PIXW-1:0] pixd_reg;
    logic            vd_reg;

    assign q_fin     = sq_root_reg[NQ-1];
    assign rem_fin   = sq_rem_reg[NQ-1];
    assign dist_next = DW'(q_fin) + DW'(rem_fin > RW'(q_fin));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (en) begin
            vd_reg <= sq_v_reg[NQ-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg <= dist_next;
            pixd_reg <= sq_pix_reg[NQ-1];
        end
    end

    // ------------------------------------------------------------------
    // Zone select and ramp operands
    // ------------------------------------------------------------------
    logic [CMPW-1:0]  dist_x, r1_x, r2_x;
    gsel_t            sel_next, sel_reg;
    logic [RAD_W-1:0] num_reg, den_reg;
    logic [PIXW-1:0]  pixc_reg;
    logic             vc_reg;

    assign dist_x = CMPW'(dist_reg);
    assign r1_x   = CMPW'(inner_radius_reg);
    assign r2_x   = CMPW'(outer_radius_reg);

    always_comb begin
        if (dist_x < r1_x) begin
            sel_next = SEL_UNITY;
        end else if (dist_x > r2_x || inner_radius_reg == outer_radius_reg) begin
            sel_next = SEL_EDGE;
        end else begin
            sel_next = SEL_RAMP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sel_reg  <= sel_next;
            num_reg  <= RAD_W'(dist_x - r1_x);
            den_reg  <= outer_radius_reg - inner_radius_reg;
            pixc_reg <= pixd_reg;
        end
    end

    // ------------------------------------------------------------------
    // Ramp position t = ((d - inner) << 16) / (outer - inner)
    // ------------------------------------------------------------------
    logic [T_W-1:0] t_quo;
    logic [PSW-1:0] t_ps;
    logic           t_v;

    rvg_div #(
        .DEN_W (RAD_W),
        .QUO_W (T_W),
        .PAY_W (PSW)
    ) u_ramp_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vc_reg),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .in_pay    ({sel_reg, pixc_reg}),
        .out_valid (t_v),
        .out_quo   (t_quo),
        .out_pay   (t_ps)
    );

    // ------------------------------------------------------------------
    // Normalise t into [1, 2) for the log
    // ------------------------------------------------------------------
    logic [K_W-1:0] k_next;
    logic [T_W-1:0] nm_m_reg;
    logic [K_W-1:0] nm_k_reg;
    logic           nm_tz_reg;
    logic [PSW-1:0] nm_ps_reg;
    logic           nm_v_reg;

    always_comb begin
        k_next = '0;
        for (int i = 0; i < T_W; i++) begin
            if (t_quo[i]) k_next = K_W'(T_W - 1 - i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nm_v_reg <= 1'b0;
        end else if (en) begin
            nm_v_reg <= t_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nm_m_reg  <= t_quo << k_next;
            nm_k_reg  <= k_next;
            nm_tz_reg <= (t_quo == '0);
            nm_ps_reg <= t_ps;
        end
    end

    // ------------------------------------------------------------------
    // log2 fraction by repeated squaring, one bit per stage
    // ------------------------------------------------------------------
    logic [T_W-1:0]    lg_m_reg  [LOG_STEPS];
    logic [FRAC_W-1:0] lg_f_reg  [LOG_STEPS];
    logic [K_W-1:0]    lg_k_reg  [LOG_STEPS];
    logic              lg_tz_reg [LOG_STEPS];
    logic [PSW-1:0]    lg_ps_reg [LOG_STEPS];
    logic              lg_v_reg  [LOG_STEPS];

    for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log
        logic [T_W-1:0]    m_in, m_next;
        logic [FRAC_W-1:0] f_in, f_next;
        logic [K_W-1:0]    k_in;
        logic              tz_in;
        logic [PSW-1:0]    ps_in;
        logic              v_in;
        logic [2*T_W-1:0]  sq;

        if (j == 0) begin : g_first
            assign m_in  = nm_m_reg;
            assign f_in  = '0;
            assign k_in  = nm_k_reg;
            assign tz_in = nm_tz_reg;
            assign ps_in = nm_ps_reg;
            assign v_in  = nm_v_reg;
        end else begin : g_next
            assign m_in  = lg_m_reg[j-1];
            assign f_in  = lg_f_reg[j-1];
            assign k_in  = lg_k_reg[j-1];
            assign tz_in = lg_tz_reg[j-1];
            assign ps_in = lg_ps_reg[j-1];
            assign v_in  = lg_v_reg[j-1];
        end

        assign sq = m_in * m_in;

        always_comb begin
            if (sq[2*T_W-1]) begin
                m_next = sq[2*T_W-1:T_W];
                f_next = {f_in[FRAC_W-2:0], 1'b1};
            end else begin
                m_next = sq[2*T_W-2:T_W-1];
                f_next = {f_in[FRAC_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                lg_v_reg[j] <= 1'b0;
            end else if (en) begin
                lg_v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                lg_m_reg[j]  <= m_next;
                lg_f_reg[j]  <= f_next;
                lg_k_reg[j]  <= k_in;
                lg_tz_reg[j] <= tz_in;
                lg_ps_reg[j] <= ps_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // -log2(t) = k - f, then times power
    // ------------------------------------------------------------------
    logic [LG_W-1:0]  lv_reg;
    logic             lv_tz_reg;
    logic [PSW-1:0]   lv_ps_reg;
    logic             lv_v_reg;
    logic [LG_W+15:0] lp_prod;
    logic [P_W-1:0]   p_val;
    logic             ip_big_reg;
    logic [IP_W-1:0]  ip_reg;
    logic [FRAC_W-1:0] fp_reg;
    logic             p_tz_reg;
    logic [PSW-1:0]   p_ps_reg;
    logic             p_v_reg;

    assign lp_prod = lv_reg * falloff_power_reg;
    assign p_val   = lp_prod[LG_W+15:12];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lv_v_reg <= 1'b0;
            p_v_reg  <= 1'b0;
        end else if (en) begin
            lv_v_reg <= lg_v_reg[LOG_STEPS-1];
            p_v_reg  <= lv_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lv_reg     <= LG_W'({lg_k_reg[LOG_STEPS-1], {FRAC_W{1'b0}}})
                          - LG_W'(lg_f_reg[LOG_STEPS-1]);
            lv_tz_reg  <= lg_tz_reg[LOG_STEPS-1];
            lv_ps_reg  <= lg_ps_reg[LOG_STEPS-1];
            ip_big_reg <= (p_val[P_W-1:FRAC_W] >= (P_W-FRAC_W)'(17));
            ip_reg     <= p_val[FRAC_W +: IP_W];
            fp_reg     <= p_val[FRAC_W-1:0];
            p_tz_reg   <= lv_tz_reg;
            p_ps_reg   <= lv_ps_reg;
        end
    end

    // ------------------------------------------------------------------
    // 2^-fp by a product of fixed roots, one fraction bit per stage
    // ------------------------------------------------------------------
    logic [R_W-1:0]    ex_r_reg   [EXP_STEPS];
    logic [FRAC_W-1:0] ex_fp_reg  [EXP_STEPS];
    logic [IP_W-1:0]   ex_ip_reg  [EXP_STEPS];
    logic              ex_big_reg [EXP_STEPS];
    logic              ex_tz_reg  [EXP_STEPS];
    logic [PSW-1:0]    ex_ps_reg  [EXP_STEPS];
    logic              ex_v_reg   [EXP_STEPS];

    for (genvar j = 0; j < EXP_STEPS; j++) begin : g_exp
        localparam logic [ROOT_W-1:0] ROOT = exp_root(j + 1);

        logic [R_W-1:0]        r_in, r_next;
        logic [FRAC_W-1:0]     fp_in;
        logic [IP_W-1:0]       ip_in;
        logic                  big_in, tz_in, v_in;
        logic [PSW-1:0]        ps_in;
        logic [R_W+ROOT_W-1:0] rp;

        if (j == 0) begin : g_first
            assign r_in   = R_W'(64'd1 << 30);
            assign fp_in  = fp_reg;
            assign ip_in  = ip_reg;
            assign big_in = ip_big_reg;
            assign tz_in  = p_tz_reg;
            assign ps_in  = p_ps_reg;
            assign v_in   = p_v_reg;
        end else begin : g_next
            assign r_in   = ex_r_reg[j-1];
            assign fp_in  = ex_fp_reg[j-1];
            assign ip_in  = ex_ip_reg[j-1];
            assign big_in = ex_big_reg[j-1];
            assign tz_in  = ex_tz_reg[j-1];
            assign ps_in  = ex_ps_reg[j-1];
            assign v_in   = ex_v_reg[j-1];
        end

        assign rp     = r_in * ROOT;
        assign r_next = fp_in[FRAC_W-1-j] ? rp[R_W+29:30] : r_in;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ex_v_reg[j] <= 1'b0;
            end else if (en) begin
                ex_v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ex_r_reg[j]   <= r_next;
                ex_fp_reg[j]  <= fp_in;
                ex_ip_reg[j]  <= ip_in;
                ex_big_reg[j] <= big_in;
                ex_tz_reg[j]  <= tz_in;
                ex_ps_reg[j]  <= ps_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Ramp value t^power in Q0.16
    // ------------------------------------------------------------------
    logic [T_W-1:0] pw_next, pw_reg;
    logic [PSW-1:0] pw_ps_reg;
    logic           pw_v_reg;
    logic [R_W-1:0] r_fin;

    assign r_fin = ex_r_reg[EXP_STEPS-1];

    always_comb begin
        if (ex_tz_reg[EXP_STEPS-1]) begin
            // t of zero: only a zero power gives one
            pw_next = (falloff_power_reg == '0) ? ONE_Q16 : '0;
        end else if (ex_big_reg[EXP_STEPS-1]) begin
            pw_next = '0;
        end else begin
            pw_next = r_fin[R_W-1:14] >> ex_ip_reg[EXP_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_v_reg <= 1'b0;
        end else if (en) begin
            pw_v_reg <= ex_v_reg[EXP_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pw_reg    <= pw_next;
            pw_ps_reg <= ex_ps_reg[EXP_STEPS-1];
        end
    end

    // ------------------------------------------------------------------
    // Gain = 1 + density * ramp, per zone
    // ------------------------------------------------------------------
    logic [T_W+15:0]   dp_prod;
    logic [GAIN_W-1:0] dp_reg;
    logic [PSW-1:0]    dp_ps_reg;
    logic              dp_v_reg;
    gsel_t             g_sel;
    logic [GAIN_W-1:0] gain_next, gain_reg;
    logic [PIXW-1:0]   pixg_reg;
    logic              vg_reg;

    assign dp_prod = pw_reg * density_reg;
    assign g_sel   = dp_ps_reg[PSW-1 -: 2];

    always_comb begin
        case (g_sel)
            SEL_UNITY: gain_next = GAIN_W'(ONE_Q16);
            SEL_EDGE:  gain_next = GAIN_W'(ONE_Q16) + GAIN_W'({density_reg, 5'b0});
            SEL_RAMP:  gain_next = GAIN_W'(ONE_Q16) + dp_reg;
            default:   gain_next = GAIN_W'(ONE_Q16);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dp_v_reg <= 1'b0;
            vg_reg   <= 1'b0;
        end else if (en) begin
            dp_v_reg <= pw_v_reg;
            vg_reg   <= dp_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dp_reg    <= dp_prod[T_W+15:11];
            dp_ps_reg <= pw_ps_reg;
            gain_reg  <= gain_next;
            pixg_reg  <= dp_ps_reg[PIXW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Reciprocal gain 2^32 / gain for add mode
    // ------------------------------------------------------------------
    logic [T_W-1:0]         rc_quo;
    logic [GAIN_W+PIXW-1:0] rc_pay;
    logic                   rc_v;
    logic [GAIN_W-1:0]      gain_use;

    rvg_div #(
        .DEN_W (GAIN_W),
        .QUO_W (T_W),
        .PAY_W (GAIN_W + PIXW)
    ) u_recip_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vg_reg),
        .in_num    (GAIN_W'(ONE_Q16)),
        .in_den    (gain_reg),
        .in_pay    ({gain_reg, pixg_reg}),
        .out_valid (rc_v),
        .out_quo   (rc_quo),
        .out_pay   (rc_pay)
    );

    assign gain_use = add_vignetting_reg ? GAIN_W'(rc_quo) : rc_pay[GAIN_W+PIXW-1:PIXW];

    // ------------------------------------------------------------------
    // Scale colour samples, then clamp into the output register
    // ------------------------------------------------------------------
    logic [SW+GAIN_W-1:0] pr_r, pr_g, pr_b;
    logic [VW-1:0]        sc_r_reg, sc_g_reg, sc_b_reg;
    logic [SW-1:0]        sc_a_reg;
    logic                 sc_v_reg;
    logic [SW-1:0]        maxv;
    logic [15:0]          red_out_reg, green_out_reg, blue_out_reg, alpha_out_reg;

    assign pr_r = rc_pay[0 +: SW]    * gain_use;
    assign pr_g = rc_pay[SW +: SW]   * gain_use;
    assign pr_b = rc_pay[2*SW +: SW] * gain_use;
    assign maxv = sixteen_bit_reg ? {SW{1'b1}} : SW'(255);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            sc_v_reg  <= rc_v;
            out_v_reg <= sc_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_r_reg      <= pr_r[SW+GAIN_W-1:16];
            sc_g_reg      <= pr_g[SW+GAIN_W-1:16];
            sc_b_reg      <= pr_b[SW+GAIN_W-1:16];
            sc_a_reg      <= rc_pay[3*SW +: SW];
            red_out_reg   <= (sc_r_reg > VW'(maxv)) ? 16'(maxv) : 16'(sc_r_reg);
            green_out_reg <= (sc_g_reg > VW'(maxv)) ? 16'(maxv) : 16'(sc_g_reg);
            blue_out_reg  <= (sc_b_reg > VW'(maxv)) ? 16'(maxv) : 16'(sc_b_reg);
            alpha_out_reg <= 16'(sc_a_reg);
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {alpha_out_reg, blue_out_reg, green_out_reg, red_out_reg};

endmodule
